### sv/cpr_pkg.sv
// cpr_pkg: shared types and codes for the clock page replacement core
// no dependencies; imported by every module of the core
package cpr_pkg;

   localparam int ADDR_W     = 32;
   localparam int DATA_W     = 32;
   localparam int PN_W       = 20;
   localparam int SLOT_W     = 5;
   localparam int WS_SIZE_W  = 6;
   localparam int WS_SIZE_MAX = (1 << WS_SIZE_W) - 1;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = 3;

   localparam logic [31:0] WS_SIZE_RESET = 32'd32;

   localparam logic OP_FAULT = 1'b0;
   localparam logic OP_REF   = 1'b1;

   localparam logic [1:0] ST_PLACED    = 2'd0;
   localparam logic [1:0] ST_REPLACED  = 2'd1;
   localparam logic [1:0] ST_ILLEGAL   = 2'd2;
   localparam logic [1:0] ST_REFERENCE = 2'd3;

   localparam logic [REG_IDX_W-1:0] REG_WS_SIZE      = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_HEAP_START   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_HEAP_MAX     = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_STACK_BOTTOM = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_STACK_TOP    = 3'd4;

   typedef struct packed {
      logic [WS_SIZE_W-1:0] ws_size;
      logic [ADDR_W-1:0]    heap_start;
      logic [ADDR_W-1:0]    heap_max;
      logic [ADDR_W-1:0]    stack_bottom;
      logic [ADDR_W-1:0]    stack_top;
   } cfg_type;

   typedef struct packed {
      logic       latch;
      logic       idx_clear;
      logic       norm_hand;
      logic       idx_load_hand;
      logic       idx_inc;
      logic       idx_wrap;
      logic       clear_used;
      logic       mem_rd;
      logic       fill;
      logic       ref_mark;
      logic       respond;
      logic [1:0] code;
      logic       resp_slot;
      logic       set_hit;
   } cmd_type;

   typedef struct packed {
      logic legal;
      logic occ_lt_size;
      logic cur_valid;
      logic cur_used;
      logic idx_last_size;
      logic idx_last_slot;
      logic pn_match;
   } stat_type;

endpackage

### sv/cpr_csr.sv
// cpr_csr: apb-style register file for working set size and legal windows
// depends on cpr_pkg
module cpr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [cpr_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [cpr_pkg::DATA_W-1:0]       pwdata,
   output logic [cpr_pkg::DATA_W-1:0]       prdata,
   output logic                             pready,
   output cpr_pkg::cfg_type                 cfg
);
   import cpr_pkg::*;

   cfg_type              cfg_ff;
   cfg_type              cfg_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_en;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_WS_SIZE:      cfg_in.ws_size      = pwdata[WS_SIZE_W-1:0];
            REG_HEAP_START:   cfg_in.heap_start   = pwdata;
            REG_HEAP_MAX:     cfg_in.heap_max     = pwdata;
            REG_STACK_BOTTOM: cfg_in.stack_bottom = pwdata;
            REG_STACK_TOP:    cfg_in.stack_top    = pwdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_WS_SIZE:      prdata = DATA_W'(cfg_ff.ws_size);
         REG_HEAP_START:   prdata = cfg_ff.heap_start;
         REG_HEAP_MAX:     prdata = cfg_ff.heap_max;
         REG_STACK_BOTTOM: prdata = cfg_ff.stack_bottom;
         REG_STACK_TOP:    prdata = cfg_ff.stack_top;
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ws_size      <= WS_SIZE_RESET[WS_SIZE_W-1:0];
         cfg_ff.heap_start   <= '0;
         cfg_ff.heap_max     <= '0;
         cfg_ff.stack_bottom <= '0;
         cfg_ff.stack_top    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### sv/cpr_ctrl.sv
// cpr_ctrl: sequencing state machine for fault placement, sweep and reference search
// depends on cpr_pkg; drives commands into cpr_dp and reads its status
module cpr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               op,
   input  cpr_pkg::stat_type  stat,
   output logic               busy,
   output cpr_pkg::cmd_type   cmd
);
   import cpr_pkg::*;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_CHECK   = 3'd1;
   localparam logic [2:0] S_PLACE   = 3'd2;
   localparam logic [2:0] S_FREE    = 3'd3;
   localparam logic [2:0] S_SWEEP   = 3'd4;
   localparam logic [2:0] S_VICTIM  = 3'd5;
   localparam logic [2:0] S_REF_RD  = 3'd6;
   localparam logic [2:0] S_REF_CMP = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.code = ST_PLACED;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch     = 1'b1;
               cmd.idx_clear = 1'b1;
               state_in      = (op == OP_REF) ? S_REF_RD : S_CHECK;
            end
         end
         S_CHECK: begin
            if (!stat.legal) begin
               cmd.respond = 1'b1;
               cmd.code    = ST_ILLEGAL;
               state_in    = S_IDLE;
            end else begin
               cmd.norm_hand = 1'b1;
               state_in      = S_PLACE;
            end
         end
         S_PLACE: begin
            if (stat.occ_lt_size && !stat.cur_valid) begin
               cmd.fill      = 1'b1;
               cmd.respond   = 1'b1;
               cmd.resp_slot = 1'b1;
               state_in      = S_IDLE;
            end else if (stat.occ_lt_size) begin
               cmd.idx_clear = 1'b1;
               state_in      = S_FREE;
            end else begin
               state_in = S_SWEEP;
            end
         end
         S_FREE: begin
            if (!stat.cur_valid) begin
               cmd.fill      = 1'b1;
               cmd.respond   = 1'b1;
               cmd.resp_slot = 1'b1;
               state_in      = S_IDLE;
            end else if (stat.idx_last_size) begin
               cmd.idx_load_hand = 1'b1;
               state_in          = S_SWEEP;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_SWEEP: begin
            if (!stat.cur_valid) begin
               cmd.fill      = 1'b1;
               cmd.respond   = 1'b1;
               cmd.resp_slot = 1'b1;
               state_in      = S_IDLE;
            end else if (!stat.cur_used) begin
               cmd.mem_rd = 1'b1;
               state_in   = S_VICTIM;
            end else begin
               cmd.clear_used = 1'b1;
               cmd.idx_wrap   = 1'b1;
            end
         end
         S_VICTIM: begin
            cmd.fill      = 1'b1;
            cmd.respond   = 1'b1;
            cmd.code      = ST_REPLACED;
            cmd.resp_slot = 1'b1;
            state_in      = S_IDLE;
         end
         S_REF_RD: begin
            if (stat.cur_valid) begin
               cmd.mem_rd = 1'b1;
               state_in   = S_REF_CMP;
            end else if (stat.idx_last_slot) begin
               cmd.respond = 1'b1;
               cmd.code    = ST_REFERENCE;
               state_in    = S_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_REF_CMP: begin
            if (stat.pn_match) begin
               cmd.ref_mark  = 1'b1;
               cmd.respond   = 1'b1;
               cmd.code      = ST_REFERENCE;
               cmd.resp_slot = 1'b1;
               cmd.set_hit   = 1'b1;
               state_in      = S_IDLE;
            end else if (stat.idx_last_slot) begin
               cmd.respond = 1'b1;
               cmd.code    = ST_REFERENCE;
               state_in    = S_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_REF_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/cpr_dp.sv
// cpr_dp: working set storage, clock hand, scan index and result registers
// depends on cpr_pkg; commanded by cpr_ctrl, configured by cpr_csr
module cpr_dp #(
   parameter int WS_DEPTH  = 32,
   parameter int PAGE_BITS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  cpr_pkg::cfg_type                cfg,
   input  cpr_pkg::cmd_type                cmd,
   output cpr_pkg::stat_type               stat,
   input  logic [cpr_pkg::ADDR_W-1:0]      req_address,
   input  logic                            req_is_write,
   input  logic                            req_in_page_file,
   output logic                            rsp_valid,
   output logic [1:0]                      rsp_status,
   output logic [cpr_pkg::SLOT_W-1:0]      rsp_slot,
   output logic [cpr_pkg::PN_W-1:0]        rsp_victim_page,
   output logic                            rsp_victim_dirty,
   output logic                            rsp_hit
);
   import cpr_pkg::*;

   // slots beyond the largest programmable size are never used
   localparam int SLOTS = (WS_DEPTH < WS_SIZE_MAX) ? WS_DEPTH : WS_SIZE_MAX;
   localparam int IDX_W = $clog2(SLOTS);
   localparam int SZ_W  = $clog2(SLOTS + 1);

   logic [PN_W-1:0]   pn_mem [SLOTS];
   logic [PN_W-1:0]   rd_data_ff;

   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [PN_W-1:0]   pn_ff, pn_in;
   logic              wr_ff, wr_in;
   logic              inpf_ff, inpf_in;
   logic [SLOTS-1:0]  valid_ff, valid_in;
   logic [SLOTS-1:0]  used_ff, used_in;
   logic [SLOTS-1:0]  mod_ff, mod_in;
   logic [IDX_W-1:0]  hand_ff, hand_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [SZ_W-1:0]   occ_ff, occ_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [PN_W-1:0]   rsp_vpage_ff, rsp_vpage_in;
   logic              rsp_vdirty_ff, rsp_vdirty_in;
   logic              rsp_hit_ff, rsp_hit_in;

   logic [ADDR_W-1:0]       addr_shift;
   logic [SZ_W-1:0]         size;
   logic [SZ_W-1:0]         idx_ext;
   logic [SZ_W-1:0]         hand_ext;
   logic [IDX_W-1:0]        hand_norm;
   logic [IDX_W-1:0]        idx_wrap_next;
   logic [IDX_W+SLOT_W-1:0] idx_slot;

   assign addr_shift = req_address >> PAGE_BITS;

   always_comb begin
      if (cfg.ws_size == '0) begin
         size = SZ_W'(1);
      end else if (cfg.ws_size > WS_SIZE_W'(SLOTS)) begin
         size = SZ_W'(SLOTS);
      end else begin
         size = SZ_W'(cfg.ws_size);
      end
   end

   assign idx_ext       = SZ_W'(idx_ff);
   assign hand_ext      = SZ_W'(hand_ff);
   assign hand_norm     = (hand_ext >= size) ? '0 : hand_ff;
   assign idx_wrap_next = ((idx_ext + SZ_W'(1)) == size) ? '0 : (idx_ff + IDX_W'(1));
   assign idx_slot      = (IDX_W+SLOT_W)'(idx_ff);

   assign stat.legal = inpf_ff ||
                       ((addr_ff >= cfg.heap_start) && (addr_ff <= cfg.heap_max)) ||
                       ((addr_ff >= cfg.stack_bottom) && (addr_ff <= cfg.stack_top));
   assign stat.occ_lt_size   = (occ_ff < size);
   assign stat.cur_valid     = valid_ff[idx_ff];
   assign stat.cur_used      = used_ff[idx_ff];
   assign stat.idx_last_size = ((idx_ext + SZ_W'(1)) == size);
   assign stat.idx_last_slot = (idx_ff == IDX_W'(SLOTS - 1));
   assign stat.pn_match      = valid_ff[idx_ff] && (rd_data_ff == pn_ff);

   always_comb begin
      addr_in  = addr_ff;
      pn_in    = pn_ff;
      wr_in    = wr_ff;
      inpf_in  = inpf_ff;
      valid_in = valid_ff;
      used_in  = used_ff;
      mod_in   = mod_ff;
      hand_in  = hand_ff;
      idx_in   = idx_ff;
      occ_in   = occ_ff;

      if (cmd.latch) begin
         addr_in = req_address;
         pn_in   = addr_shift[PN_W-1:0];
         wr_in   = req_is_write;
         inpf_in = req_in_page_file;
      end

      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.norm_hand) begin
         idx_in = hand_norm;
      end else if (cmd.idx_load_hand) begin
         idx_in = hand_ff;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IDX_W'(1);
      end else if (cmd.idx_wrap) begin
         idx_in = idx_wrap_next;
      end

      if (cmd.norm_hand) begin
         hand_in = hand_norm;
      end

      if (cmd.clear_used) begin
         used_in[idx_ff] = 1'b0;
      end

      if (cmd.ref_mark) begin
         used_in[idx_ff] = 1'b1;
         if (wr_ff) begin
            mod_in[idx_ff] = 1'b1;
         end
      end

      if (cmd.fill) begin
         valid_in[idx_ff] = 1'b1;
         used_in[idx_ff]  = 1'b1;
         mod_in[idx_ff]   = 1'b0;
         hand_in          = idx_wrap_next;
         if (!valid_ff[idx_ff]) begin
            occ_in = occ_ff + SZ_W'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in  = cmd.respond;
      rsp_status_in = cmd.code;
      rsp_slot_in   = cmd.resp_slot ? idx_slot[SLOT_W-1:0] : '0;
      rsp_vpage_in  = (cmd.code == ST_REPLACED) ? rd_data_ff : '0;
      rsp_vdirty_in = (cmd.code == ST_REPLACED) ? mod_ff[idx_ff] : 1'b0;
      rsp_hit_in    = cmd.set_hit;
   end

   // page number store
   always_ff @(posedge clock) begin
      if (cmd.fill) begin
         pn_mem[idx_ff] <= pn_ff;
      end
      if (cmd.mem_rd) begin
         rd_data_ff <= pn_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         used_ff      <= '0;
         mod_ff       <= '0;
         hand_ff      <= '0;
         idx_ff       <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         used_ff      <= used_in;
         mod_ff       <= mod_in;
         hand_ff      <= hand_in;
         idx_ff       <= idx_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      pn_ff         <= pn_in;
      wr_ff         <= wr_in;
      inpf_ff       <= inpf_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_vpage_ff  <= rsp_vpage_in;
      rsp_vdirty_ff <= rsp_vdirty_in;
      rsp_hit_ff    <= rsp_hit_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_victim_page  = rsp_vpage_ff;
   assign rsp_victim_dirty = rsp_vdirty_ff;
   assign rsp_hit          = rsp_hit_ff;

`ifndef SYNTHESIS
   a_occ_matches_valid: assert property (@(posedge clock) disable iff (reset)
      occ_ff == SZ_W'($countones(valid_ff)))
      else $error("occupancy count disagrees with valid marks");

   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.fill |-> (idx_ext < size))
      else $error("fill outside working set size");

   a_victim_unused: assert property (@(posedge clock) disable iff (reset)
      (cmd.fill && (cmd.code == ST_REPLACED)) |-> (valid_ff[idx_ff] && !used_ff[idx_ff]))
      else $error("victim slot not valid or still marked used");

   a_fill_hand_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.fill |=> (hand_ext < size))
      else $error("clock hand left outside working set size");
`endif

endmodule

### sv/clock_page_replacement_core.sv
// clock_page_replacement_core: top level, joins registers, controller and datapath
// fault: check legality and try the hand slot, then either a free-slot scan over up to size
//   slots or a hand sweep that clears used marks until an unused slot, then evict; size being
//   ws_size clamped to 1..min(WS_DEPTH, 63); reference: scans from slot 0, reading the
//   single-port page store for each valid slot and comparing, until a match or the last slot
// result appears the cycle after the last step; start is taken again that same cycle
// synchronous reset empties the working set, zeroes hand and count, size back to 32
module clock_page_replacement_core #(
   parameter int WS_DEPTH  = 32,
   parameter int PAGE_BITS = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_operation,
   input  logic [cpr_pkg::ADDR_W-1:0]       req_address,
   input  logic                             req_is_write,
   input  logic                             req_in_page_file,
   output logic                             rsp_valid,
   output logic [1:0]                       rsp_status,
   output logic [cpr_pkg::SLOT_W-1:0]       rsp_slot,
   output logic [cpr_pkg::PN_W-1:0]         rsp_victim_page,
   output logic                             rsp_victim_dirty,
   output logic                             rsp_hit,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [cpr_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [cpr_pkg::DATA_W-1:0]       pwdata,
   output logic [cpr_pkg::DATA_W-1:0]       prdata,
   output logic                             pready
);
   import cpr_pkg::*;

   cfg_type  cfg;
   cmd_type  cmd;
   stat_type stat;

   cpr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   cpr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .op    (req_operation),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   cpr_dp #(
      .WS_DEPTH  (WS_DEPTH),
      .PAGE_BITS (PAGE_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .stat             (stat),
      .req_address      (req_address),
      .req_is_write     (req_is_write),
      .req_in_page_file (req_in_page_file),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_slot         (rsp_slot),
      .rsp_victim_page  (rsp_victim_page),
      .rsp_victim_dirty (rsp_victim_dirty),
      .rsp_hit          (rsp_hit)
   );

endmodule
